// File: rtl/neighbour_presence_tracker_top_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the neighbour presence tracker
// ----------------------------------------------------------------------------
`ifndef NEIGHBOUR_PRESENCE_TRACKER_TOP_DEFINES_SVH
`define NEIGHBOUR_PRESENCE_TRACKER_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is low
`define NPT_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is low
`define NPT_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/npt_pkg.sv
// ----------------------------------------------------------------------------
// npt_pkg
// Shared types and constants of the neighbour presence tracker.
// ----------------------------------------------------------------------------
package npt_pkg;

    localparam int unsigned MAX_NODES_DEF = 16;

    localparam logic signed [7:0] RSSI_THR_RST   = -8'sd65;
    localparam logic [31:0]       DETECT_TCK_RST = 32'd1920;
    localparam logic [31:0]       ABSENT_TCK_RST = 32'd3840;
    localparam logic [31:0]       SWEEP_TCK_RST  = 32'd768;

    // configuration register indexes
    localparam logic [1:0] CFG_RSSI_THR   = 2'd0;
    localparam logic [1:0] CFG_DETECT_TCK = 2'd1;
    localparam logic [1:0] CFG_ABSENT_TCK = 2'd2;
    localparam logic [1:0] CFG_SWEEP_TCK  = 2'd3;

    localparam logic ACT_BEACON = 1'b0;
    localparam logic ACT_SWEEP  = 1'b1;

    localparam logic EV_DETECT = 1'b0;
    localparam logic EV_ABSENT = 1'b1;

    // command broadcast to every cell while an item walks the chain
    typedef struct packed {
        logic        sweep;
        logic [15:0] node;
        logic        nonneg;
        logic        is_strong;
        logic [31:0] now;
        logic [31:0] detect;
        logic [31:0] absent;
    } t_cmd;

    // event raised by the cell that holds the token
    typedef struct packed {
        logic        valid;
        logic        kind;
        logic [15:0] node;
        logic [31:0] time_of;
    } t_ev;

endpackage

// File: rtl/npt_cell.sv
// ----------------------------------------------------------------------------
// npt_cell
// One table entry. Processes the command when the walking token sits here,
// then hands the token and the found flag to the next cell.
// ----------------------------------------------------------------------------
module npt_cell #(
    parameter int unsigned MAX_NODES = 16,
    parameter int unsigned IDX       = 0
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_adv,
    input  npt_pkg::t_cmd                       i_cmd,
    input  logic [$clog2(MAX_NODES+1)-1:0]      i_count,
    input  logic                                i_tok,
    input  logic                                i_found,
    output logic                                o_tok,
    output logic                                o_found,
    output npt_pkg::t_ev                        o_ev,
    output logic                                o_ins
);
    import npt_pkg::*;

    localparam int unsigned CNT_W = $clog2(MAX_NODES + 1);
    localparam logic [CNT_W-1:0] MY_IDX = CNT_W'(IDX);

    logic        r_tok;
    logic        r_found;
    logic [15:0] r_id;
    logic        r_present;
    logic        r_timing;
    logic        r_fade_on;
    logic [31:0] r_since;
    logic [31:0] r_fading;

    logic        w_used;
    logic        w_hit;
    logic        w_ins;
    logic        w_pres;
    logic        w_timing;
    logic        w_fade;
    logic [31:0] w_base;
    logic [31:0] w_lim;
    logic [31:0] w_diff;
    logic        w_due;
    logic        w_bcn;
    logic        w_det;
    logic        w_abs_b;
    logic        w_abs_s;

    always_comb begin
        w_used   = (MY_IDX < i_count);
        w_hit    = !i_cmd.sweep && w_used && (r_id == i_cmd.node);
        // first free slot takes an unknown id
        w_ins    = !i_cmd.sweep && (MY_IDX == i_count) && !r_found;
        w_pres   = w_ins ? 1'b0 : r_present;
        w_timing = w_ins ? 1'b0 : r_timing;
        w_fade   = w_ins ? 1'b0 : r_fade_on;
        w_base   = (i_cmd.sweep || i_cmd.is_strong) ? r_since : r_fading;
        w_lim    = (!i_cmd.sweep && i_cmd.is_strong) ? i_cmd.detect : i_cmd.absent;
        w_diff   = i_cmd.now - w_base;
        w_due    = (w_diff >= w_lim);
        w_bcn    = (w_hit || w_ins) && !i_cmd.nonneg;
        w_det    = w_hit && !i_cmd.nonneg && i_cmd.is_strong && !r_present && r_timing
                   && w_due;
        w_abs_b  = w_hit && !i_cmd.nonneg && !i_cmd.is_strong && r_present && r_fade_on
                   && w_due;
        w_abs_s  = i_cmd.sweep && w_used && r_present && w_due;
    end

    assign o_tok   = r_tok;
    assign o_found = r_found || w_hit || w_ins;
    assign o_ins   = r_tok && w_ins;

    always_comb begin
        o_ev.valid   = r_tok && (w_det || w_abs_b || w_abs_s);
        o_ev.kind    = w_det ? EV_DETECT : EV_ABSENT;
        o_ev.node    = r_id;
        o_ev.time_of = w_abs_b ? r_fading : r_since;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok   <= 1'b0;
            r_found <= 1'b0;
        end else if (i_adv) begin
            r_tok   <= i_tok;
            r_found <= i_found;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv && r_tok) begin
            if (w_ins) begin
                r_id      <= i_cmd.node;
                r_present <= 1'b0;
                r_timing  <= 1'b0;
                r_fade_on <= 1'b0;
            end
            if (w_bcn) begin
                if (i_cmd.is_strong) begin
                    if (w_pres || !w_timing) begin
                        r_since  <= i_cmd.now;
                        r_timing <= 1'b1;
                    end else if (w_due) begin
                        r_present <= 1'b1;
                        r_fade_on <= 1'b0;
                    end
                end else if (!w_pres) begin
                    r_timing <= 1'b0;
                end else if (!w_fade) begin
                    r_fading  <= i_cmd.now;
                    r_fade_on <= 1'b1;
                end else if (w_due) begin
                    r_present <= 1'b0;
                    r_timing  <= 1'b0;
                end
            end
            if (w_abs_s) begin
                r_present <= 1'b0;
                r_timing  <= 1'b0;
            end
        end
    end

endmodule

// File: rtl/neighbour_presence_tracker_top.sv
// ----------------------------------------------------------------------------
// neighbour_presence_tracker_top
// Neighbour table built as a chain of entry cells; a token walks the chain
// once per non-sender beacon or effective sweep and collects DETECT / ABSENT events.
// ----------------------------------------------------------------------------
//   channel | direction | handshake                 | payload
//   in      | input     | i_in_valid / o_in_ready   | action, node_id, rssi,
//           |           |                           | sender_role, now_ticks
//   out     | output    | o_out_valid / i_out_ready | event_kind, event_node,
//           |           |                           | event_time, last_of_run
//   cfg     | input     | i_cfg_we                  | i_cfg_index, i_cfg_data
//
// A beacon or effective sweep is accepted, then the token walks the chain cell
// by cell, and a flush state ends the run.
// A sender-role beacon or an early sweep is accepted without a walk and gives no item.
// The walk stalls on a cell that raises an event while the output register
// and the pending event register are both full; the flush cycle likewise
// waits for a free output register.
// Reset is synchronous; no clearing pass is needed after it.
// ----------------------------------------------------------------------------
`include "neighbour_presence_tracker_top_defines.svh"

module neighbour_presence_tracker_top #(
    parameter int unsigned MAX_NODES = npt_pkg::MAX_NODES_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic               i_action,
    input  logic [15:0]        i_node_id,
    input  logic signed [7:0]  i_rssi,
    input  logic               i_sender_role,
    input  logic [31:0]        i_now_ticks,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic               o_event_kind,
    output logic [15:0]        o_event_node,
    output logic [31:0]        o_event_time,
    output logic               o_last_of_run,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_index,
    input  logic [31:0]        i_cfg_data
);
    import npt_pkg::*;

    localparam int unsigned CNT_W = $clog2(MAX_NODES + 1);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_WALK  = 2'd1;
    localparam logic [1:0] S_FLUSH = 2'd2;

    logic [1:0]        r_state;
    logic [1:0]        n_state;

    logic signed [7:0] r_rssi_thr;
    logic [31:0]       r_detect_tck;
    logic [31:0]       r_absent_tck;
    logic [31:0]       r_sweep_tck;

    logic [CNT_W-1:0]  r_count;
    logic [31:0]       r_last_sweep;

    logic              r_cmd_sweep;
    logic [15:0]       r_cmd_node;
    logic              r_cmd_nonneg;
    logic              r_cmd_strong;
    logic [31:0]       r_cmd_now;
    t_cmd              w_cmd;

    logic              r_pnd_valid;
    t_ev               r_pnd;

    logic              r_out_valid;
    logic              r_out_kind;
    logic [15:0]       r_out_node;
    logic [31:0]       r_out_time;
    logic              r_out_last;

    logic [MAX_NODES:0]   w_tok;
    logic [MAX_NODES:0]   w_fnd;
    logic [MAX_NODES-1:0] w_ins;
    logic [MAX_NODES-1:0] w_ev_hit;
    t_ev                  w_ev_vec [MAX_NODES];
    t_ev                  w_ev;

    logic              w_accept;
    logic              w_early;
    logic              w_start;
    logic              w_out_free;
    logic              w_adv;
    logic              w_push_pnd;
    logic              w_flush;

    assign o_in_ready = (r_state == S_IDLE);
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_early    = ((i_now_ticks - r_last_sweep) < r_sweep_tck);
    assign w_start    = w_accept && ((i_action == ACT_SWEEP) ? !w_early : !i_sender_role);
    assign w_out_free = !r_out_valid || i_out_ready;

    // hold the walk while an event has nowhere to go
    assign w_adv      = (r_state == S_WALK) ? (!w_ev.valid || !r_pnd_valid || w_out_free)
                                            : 1'b1;
    assign w_push_pnd = (r_state == S_WALK) && w_adv && w_ev.valid && r_pnd_valid;
    assign w_flush    = (r_state == S_FLUSH) && r_pnd_valid && w_out_free;

    always_comb begin
        w_cmd.sweep     = r_cmd_sweep;
        w_cmd.node      = r_cmd_node;
        w_cmd.nonneg    = r_cmd_nonneg;
        w_cmd.is_strong = r_cmd_strong;
        w_cmd.now       = r_cmd_now;
        w_cmd.detect    = r_detect_tck;
        w_cmd.absent    = r_absent_tck;
    end

    assign w_tok[0] = w_start;
    assign w_fnd[0] = 1'b0;

    for (genvar g = 0; g < MAX_NODES; g++) begin : g_cell
        npt_cell #(
            .MAX_NODES (MAX_NODES),
            .IDX       (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_adv   (w_adv),
            .i_cmd   (w_cmd),
            .i_count (r_count),
            .i_tok   (w_tok[g]),
            .i_found (w_fnd[g]),
            .o_tok   (w_tok[g+1]),
            .o_found (w_fnd[g+1]),
            .o_ev    (w_ev_vec[g]),
            .o_ins   (w_ins[g])
        );
        assign w_ev_hit[g] = w_ev_vec[g].valid;
    end

    // only the token holder can raise an event; drop the fields of idle cells
    always_comb begin
        w_ev = '0;
        for (int k = 0; k < MAX_NODES; k++) begin
            if (w_ev_vec[k].valid) begin
                w_ev = w_ev | w_ev_vec[k];
            end
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_start) begin
                    n_state = S_WALK;
                end
            end
            S_WALK: begin
                if (w_adv && w_tok[MAX_NODES]) begin
                    n_state = S_FLUSH;
                end
            end
            S_FLUSH: begin
                if (!r_pnd_valid || w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_rssi_thr   <= RSSI_THR_RST;
            r_detect_tck <= DETECT_TCK_RST;
            r_absent_tck <= ABSENT_TCK_RST;
            r_sweep_tck  <= SWEEP_TCK_RST;
            r_count      <= '0;
            r_last_sweep <= '0;
            r_pnd_valid  <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_RSSI_THR:   r_rssi_thr   <= i_cfg_data[7:0];
                    CFG_DETECT_TCK: r_detect_tck <= i_cfg_data;
                    CFG_ABSENT_TCK: r_absent_tck <= i_cfg_data;
                    CFG_SWEEP_TCK:  r_sweep_tck  <= i_cfg_data;
                    default: ;
                endcase
            end
            if (w_adv && (|w_ins)) begin
                r_count <= r_count + 1'b1;
            end
            if (w_start && (i_action == ACT_SWEEP)) begin
                r_last_sweep <= i_now_ticks;
            end
            if ((r_state == S_WALK) && w_adv && w_ev.valid) begin
                r_pnd_valid <= 1'b1;
            end else if (w_flush) begin
                r_pnd_valid <= 1'b0;
            end
            if (w_push_pnd || w_flush) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_cmd_sweep  <= i_action;
            r_cmd_node   <= i_node_id;
            r_cmd_nonneg <= !i_rssi[7];
            r_cmd_strong <= (i_rssi >= r_rssi_thr);
            r_cmd_now    <= i_now_ticks;
        end
        if ((r_state == S_WALK) && w_adv && w_ev.valid) begin
            r_pnd <= w_ev;
        end
        if (w_push_pnd || w_flush) begin
            r_out_kind <= r_pnd.kind;
            r_out_node <= r_pnd.node;
            r_out_time <= r_pnd.time_of;
            r_out_last <= w_flush;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_event_kind  = r_out_kind;
    assign o_event_node  = r_out_node;
    assign o_event_time  = r_out_time;
    assign o_last_of_run = r_out_last;

    `NPT_ASSERT_NOW(a_tok_single, i_clk, i_rst_n, 1'b1, $onehot0(w_tok[MAX_NODES:1]), "more than one token in the chain")
    `NPT_ASSERT_NOW(a_ev_single, i_clk, i_rst_n, 1'b1, $onehot0(w_ev_hit), "events from more than one cell")
    `NPT_ASSERT_NOW(a_count_max, i_clk, i_rst_n, 1'b1, r_count <= CNT_W'(MAX_NODES), "entry count beyond table size")
    `NPT_ASSERT_NEXT(a_walk_end, i_clk, i_rst_n, (r_state == S_WALK) && w_adv && w_tok[MAX_NODES], r_state == S_FLUSH, "walk end did not reach flush")
    `NPT_ASSERT_NOW(a_idle_clean, i_clk, i_rst_n, r_state == S_IDLE, !r_pnd_valid && (w_tok[MAX_NODES:1] == '0), "idle with work in flight")

endmodule

// File: dv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Neighbour presence tracker testbench
// Drives beacon and sweep items through the valid/ready input channel with
// random gaps, stalls the result channel at random, and checks every DETECT /
// ABSENT result against a presence table kept in the testbench.
// ----------------------------------------------------------------------------
module testbench;
    import npt_pkg::*;

    localparam int unsigned TABLE_SIZE    = MAX_NODES_DEF;
    localparam int unsigned SETTLE_CYCLES = 2 * (TABLE_SIZE + 2);
    localparam int unsigned CYCLE_LIMIT   = 600000;
    localparam int unsigned POOL_SIZE     = 20;

    typedef struct {
        logic              action;
        logic [15:0]       node;
        logic signed [7:0] rssi;
        logic              sender;
        logic [31:0]       now;
    } radio_item_t;

    typedef struct packed {
        logic        kind;
        logic [15:0] node;
        logic [31:0] stamp;
        logic        last_of_run;
    } presence_event_t;

    logic              clk;
    logic              rst_n = 1'b0;
    logic              in_valid = 1'b0;
    logic              item_action = 1'b0;
    logic [15:0]       item_node = '0;
    logic signed [7:0] item_rssi = '0;
    logic              item_sender = 1'b0;
    logic [31:0]       item_now = '0;
    logic              out_ready = 1'b0;
    logic              cfg_we = 1'b0;
    logic [1:0]        cfg_index = '0;
    logic [31:0]       cfg_data = '0;

    wire               in_ready;
    wire               out_valid;
    wire               ev_kind;
    wire [15:0]        ev_node;
    wire [31:0]        ev_time;
    wire               ev_last;

    // testbench copy of the registers
    logic signed [7:0] cfg_thr    = RSSI_THR_RST;
    logic [31:0]       cfg_detect = DETECT_TCK_RST;
    logic [31:0]       cfg_absent = ABSENT_TCK_RST;
    logic [31:0]       cfg_sweep  = SWEEP_TCK_RST;

    // testbench copy of the neighbour table
    logic [15:0]       tbl_id      [TABLE_SIZE];
    logic              tbl_present [TABLE_SIZE];
    logic              tbl_timing  [TABLE_SIZE];
    logic              tbl_fade_on [TABLE_SIZE];
    logic [31:0]       tbl_since   [TABLE_SIZE];
    logic [31:0]       tbl_fading  [TABLE_SIZE];
    int unsigned       tbl_used = 0;
    logic [31:0]       sweep_mark = '0;

    radio_item_t       radio_queue[$];
    presence_event_t   awaited_events[$];
    radio_item_t       cur;
    logic              in_taken = 1'b0;
    int unsigned       in_gap = 0;
    int unsigned       out_stall = 0;
    logic              idle_on = 1'b1;
    int unsigned       fault_count = 0;
    int unsigned       cycle_count;

    logic [15:0]       id_pool [POOL_SIZE];
    logic [31:0]       tick_now;
    logic [31:0]       t0;
    logic signed [7:0] thr_pick;
    logic [31:0]       det_pick;
    logic [31:0]       abs_pick;
    logic [31:0]       swp_pick;

    neighbour_presence_tracker_top #(
        .MAX_NODES(TABLE_SIZE)
    ) dut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (in_valid),
        .o_in_ready    (in_ready),
        .i_action      (item_action),
        .i_node_id     (item_node),
        .i_rssi        (item_rssi),
        .i_sender_role (item_sender),
        .i_now_ticks   (item_now),
        .o_out_valid   (out_valid),
        .i_out_ready   (out_ready),
        .o_event_kind  (ev_kind),
        .o_event_node  (ev_node),
        .o_event_time  (ev_time),
        .o_last_of_run (ev_last),
        .i_cfg_we      (cfg_we),
        .i_cfg_index   (cfg_index),
        .i_cfg_data    (cfg_data)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic logic [31:0] ticks_since(input logic [31:0] now, input logic [31:0] t);
        return now - t;
    endfunction

    // Work out the results of one accepted item and update the table copy.
    task automatic predict_presence(input radio_item_t it);
        int unsigned     k;
        int unsigned     slot;
        logic            found;
        presence_event_t ev;
        presence_event_t batch[$];
        if (it.action == ACT_SWEEP) begin
            if (ticks_since(it.now, sweep_mark) >= cfg_sweep) begin
                sweep_mark = it.now;
                for (k = 0; k < tbl_used; k++) begin
                    if (tbl_present[k] && ticks_since(it.now, tbl_since[k]) >= cfg_absent) begin
                        ev = '{EV_ABSENT, tbl_id[k], tbl_since[k], 1'b0};
                        batch.push_back(ev);
                        tbl_present[k] = 1'b0;
                        tbl_timing[k]  = 1'b0;
                        tbl_since[k]   = '0;
                    end
                end
            end
        end else if (!it.sender) begin
            found = 1'b0;
            slot  = tbl_used;
            for (k = 0; k < tbl_used; k++) begin
                if (!found && tbl_id[k] == it.node) begin
                    slot  = k;
                    found = 1'b1;
                end
            end
            // insert an unknown id as absent while there is room, else drop it
            if (!found && tbl_used < TABLE_SIZE) begin
                tbl_id[slot]      = it.node;
                tbl_present[slot] = 1'b0;
                tbl_timing[slot]  = 1'b0;
                tbl_fade_on[slot] = 1'b0;
                tbl_since[slot]   = '0;
                tbl_fading[slot]  = '0;
                tbl_used++;
                found = 1'b1;
            end
            if (found && it.rssi[7]) begin
                if (it.rssi >= cfg_thr) begin
                    if (tbl_present[slot] || !tbl_timing[slot]) begin
                        tbl_since[slot]  = it.now;
                        tbl_timing[slot] = 1'b1;
                    end else if (ticks_since(it.now, tbl_since[slot]) >= cfg_detect) begin
                        tbl_present[slot] = 1'b1;
                        tbl_fade_on[slot] = 1'b0;
                        tbl_fading[slot]  = '0;
                        ev = '{EV_DETECT, it.node, tbl_since[slot], 1'b0};
                        batch.push_back(ev);
                    end
                end else if (!tbl_present[slot]) begin
                    tbl_timing[slot] = 1'b0;
                    tbl_since[slot]  = '0;
                end else if (!tbl_fade_on[slot]) begin
                    tbl_fading[slot]  = it.now;
                    tbl_fade_on[slot] = 1'b1;
                end else if (ticks_since(it.now, tbl_fading[slot]) >= cfg_absent) begin
                    tbl_present[slot] = 1'b0;
                    tbl_timing[slot]  = 1'b0;
                    tbl_since[slot]   = '0;
                    ev = '{EV_ABSENT, it.node, tbl_fading[slot], 1'b0};
                    batch.push_back(ev);
                end
            end
        end
        if (batch.size() > 0)
            batch[batch.size() - 1].last_of_run = 1'b1;
        foreach (batch[i])
            awaited_events.push_back(batch[i]);
    endtask

    // Accept side: predict on every item that crosses the input handshake.
    always @(posedge clk) begin
        if (rst_n && in_valid && in_ready) begin
            predict_presence(cur);
            in_taken = 1'b1;
        end
    end

    // Driver: present the next queued item once the slot is free.
    always @(negedge clk) begin
        if (rst_n && (!in_valid || in_taken)) begin
            if (!idle_on)
                in_gap = 0;
            else if (in_gap > 0)
                in_gap--;
            else if ($urandom_range(0, 3) == 0)
                in_gap = $urandom_range(1, 17);
            if (in_gap == 0 && radio_queue.size() > 0) begin
                cur = radio_queue.pop_front();
                item_action <= cur.action;
                item_node   <= cur.node;
                item_rssi   <= cur.rssi;
                item_sender <= cur.sender;
                item_now    <= cur.now;
                in_valid    <= 1'b1;
            end else begin
                in_valid <= 1'b0;
            end
            in_taken = 1'b0;
        end
    end

    // Result side back-pressure.
    always @(negedge clk) begin
        if (!idle_on)
            out_stall = 0;
        else if (out_stall > 0)
            out_stall--;
        else if ($urandom_range(0, 5) == 0)
            out_stall = $urandom_range(1, 17);
        out_ready <= (out_stall == 0);
    end

    task automatic compare_field(input string label, input logic [31:0] want,
                                 input logic [31:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch: expected %h, got %h", $time, label, want, got);
            fault_count++;
        end
    endtask

    // Monitor: check each result against the oldest expectation.
    always @(posedge clk) begin
        presence_event_t want;
        if (rst_n && out_valid && out_ready) begin
            if (awaited_events.size() == 0) begin
                $display("%0t: unexpected result: expected none, got kind %0d node %h time %h last %0d",
                         $time, ev_kind, ev_node, ev_time, ev_last);
                fault_count++;
            end else begin
                want = awaited_events.pop_front();
                compare_field("event_kind", 32'(want.kind), 32'(ev_kind));
                compare_field("event_node", 32'(want.node), 32'(ev_node));
                compare_field("event_time", want.stamp, ev_time);
                compare_field("last_of_run", 32'(want.last_of_run), 32'(ev_last));
            end
        end
    end

    task automatic queue_item(input logic action, input logic [15:0] node,
                              input logic [7:0] rssi, input logic sender,
                              input logic [31:0] now);
        radio_item_t it;
        it.action = action;
        it.node   = node;
        it.rssi   = rssi;
        it.sender = sender;
        it.now    = now;
        radio_queue.push_back(it);
    endtask

    // Write all four registers back to back; only called while the block is idle.
    task automatic program_regs(input logic signed [7:0] thr, input logic [31:0] det,
                                input logic [31:0] absent_v, input logic [31:0] swp);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_RSSI_THR;
        cfg_data  <= {{24{thr[7]}}, thr};
        @(negedge clk);
        cfg_index <= CFG_DETECT_TCK;
        cfg_data  <= det;
        @(negedge clk);
        cfg_index <= CFG_ABSENT_TCK;
        cfg_data  <= absent_v;
        @(negedge clk);
        cfg_index <= CFG_SWEEP_TCK;
        cfg_data  <= swp;
        @(negedge clk);
        cfg_we <= 1'b0;
        cfg_thr    = thr;
        cfg_detect = det;
        cfg_absent = absent_v;
        cfg_sweep  = swp;
    endtask

    // Hold until every item is in and every result is out, then cover the walk.
    task automatic settle();
        while (radio_queue.size() != 0 || in_valid || awaited_events.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Strong or weak rssi for the current threshold; falls back when one side is empty.
    function automatic logic signed [7:0] pick_rssi(input logic loud);
        int lo;
        int hi;
        if (loud && cfg_thr < 0) begin
            lo = cfg_thr;
            hi = -1;
        end else if (cfg_thr > -128) begin
            lo = -128;
            hi = cfg_thr - 1;
        end else begin
            lo = -128;
            hi = -1;
        end
        return 8'(lo + int'($urandom_range(hi - lo, 0)));
    endfunction

    // Mostly runs of beacons on one neighbour, mixed with sweeps and noise.
    task automatic run_traffic(input int count, input int unsigned step_max);
        int          made;
        int          pick;
        int          len;
        logic [15:0] who;
        logic        loud;
        made = 0;
        while (made < count) begin
            pick = $urandom_range(0, 99);
            if (pick < 14) begin
                tick_now += $urandom_range(0, step_max);
                queue_item(ACT_SWEEP, 16'($urandom), 8'($urandom), 1'($urandom), tick_now);
                made++;
            end else if (pick < 22) begin
                queue_item(ACT_BEACON, 16'($urandom), 8'($urandom), 1'b1, $urandom);
            end else if (pick < 27) begin
                queue_item(ACT_BEACON, id_pool[$urandom_range(0, POOL_SIZE - 1)],
                           8'($urandom_range(0, 127)), 1'b0, tick_now);
            end else if (pick < 31) begin
                tick_now += $urandom_range(0, step_max);
                queue_item(ACT_BEACON, 16'($urandom), 8'($urandom), 1'b0, tick_now);
                made++;
            end else begin
                who  = id_pool[$urandom_range(0, POOL_SIZE - 1)];
                loud = ($urandom_range(0, 3) != 0);
                len  = $urandom_range(1, 4);
                repeat (len) begin
                    tick_now += $urandom_range(0, step_max);
                    if ($urandom_range(0, 7) == 0)
                        loud = !loud;
                    queue_item(ACT_BEACON, who, pick_rssi(loud), 1'b0, tick_now);
                    made++;
                end
            end
        end
    endtask

    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("%0t: timeout, %0d results still awaited", $time, awaited_events.size());
        $display("FAILED: results differ");
        $finish;
    end

    initial begin
        id_pool[0] = 16'h0000;
        id_pool[1] = 16'hFFFF;
        for (int i = 2; i < POOL_SIZE; i++)
            id_pool[i] = 16'($urandom);
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed part at the reset register values, crossing the time wrap
        t0 = 32'hFFFF_F000;
        queue_item(ACT_BEACON, 16'h0042, -8'sd30, 1'b1, t0);          // sender role: ignored
        queue_item(ACT_SWEEP, 16'h0000, 8'h00, 1'b0, t0);             // effective, table empty
        queue_item(ACT_BEACON, 16'h0000, 8'sd127, 1'b0, t0);          // insert, non-negative
        queue_item(ACT_BEACON, 16'h0000, 8'sd0, 1'b0, t0);            // zero rssi
        queue_item(ACT_BEACON, 16'h0000, -8'sd65, 1'b0, t0 + 10);     // strong at threshold
        queue_item(ACT_BEACON, 16'h0000, -8'sd1, 1'b0, t0 + 1929);    // one tick short
        queue_item(ACT_BEACON, 16'h0000, -8'sd66, 1'b0, t0 + 2000);   // weak: candidate reset
        queue_item(ACT_BEACON, 16'h0000, -8'sd1, 1'b0, t0 + 2100);
        queue_item(ACT_BEACON, 16'h0000, -8'sd40, 1'b0, t0 + 4020);   // detect
        queue_item(ACT_BEACON, 16'hFFFF, -8'sd65, 1'b0, t0 + 4100);
        queue_item(ACT_BEACON, 16'hFFFF, -8'sd50, 1'b0, t0 + 6100);   // detect
        queue_item(ACT_BEACON, 16'h0000, -8'sd20, 1'b0, t0 + 6200);   // refresh while present
        queue_item(ACT_BEACON, 16'h0000, -8'sd128, 1'b0, t0 + 6300);  // fading starts
        queue_item(ACT_BEACON, 16'h0000, -8'sd100, 1'b0, t0 + 10139); // one tick short
        queue_item(ACT_BEACON, 16'h0000, -8'sd66, 1'b0, t0 + 10140);  // absent by fading
        queue_item(ACT_SWEEP, 16'h0000, 8'h00, 1'b0, t0 + 10200);     // sweeps out FFFF
        queue_item(ACT_SWEEP, 16'h0000, 8'h00, 1'b0, t0 + 10967);     // too early
        queue_item(ACT_SWEEP, 16'h0000, 8'h00, 1'b0, t0 + 10968);     // exactly on interval
        queue_item(ACT_BEACON, 16'h1234, -8'sd90, 1'b0, t0 + 11000);  // new id, weak
        tick_now = t0 + 11000;
        settle();
        run_traffic(25, 1200);
        settle();

        // low extremes: every negative rssi strong, zero delays, sweep every time
        program_regs(-8'sd128, 32'd0, 32'd0, 32'd0);
        run_traffic(28, 40);
        settle();

        // high extremes: nothing strong, maximal delays
        program_regs(8'sd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        tick_now = sweep_mark - 1;
        queue_item(ACT_SWEEP, 16'h0000, 8'h00, 1'b0, tick_now);        // elapsed is all ones
        run_traffic(12, 1000);
        settle();

        for (int phase = 0; phase < 3; phase++) begin
            idle_on  = (phase != 0);
            thr_pick = 8'(-int'($urandom_range(0, 128)));
            det_pick = $urandom_range(0, 3000);
            abs_pick = $urandom_range(0, 6000);
            swp_pick = $urandom_range(0, 2000);
            program_regs(thr_pick, det_pick, abs_pick, swp_pick);
            run_traffic(28, det_pick / 2 + abs_pick / 3 + 50);
            settle();
        end

        // closing stretch at full rate
        idle_on = 1'b0;
        program_regs(RSSI_THR_RST, DETECT_TCK_RST, ABSENT_TCK_RST, SWEEP_TCK_RST);
        run_traffic(28, 1200);
        settle();

        if (awaited_events.size() != 0) begin
            $display("%0t: %0d expected results never arrived", $time, awaited_events.size());
            fault_count++;
        end
        if (fault_count == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
